/* rtl/dtq_pkg.sv */
// Shared types, constants and codes for the dual ticket queue.
package dtq_pkg;

  // Queue geometry
  localparam int DEPTH       = 16;
  localparam int TICKET_BITS = 16;
  localparam int FILL_W      = $clog2(DEPTH + 1);

  // Fixed port widths
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int TKT_W    = 16;
  localparam int NAME_W   = 64;
  localparam int COUNT_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_MOVE   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ROW_HOLD   = 2'd0,
    ROW_PUSH   = 2'd1,
    ROW_INSERT = 2'd2,
    ROW_POP    = 2'd3
  } row_op_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_CMP  = 2'd1,
    S_UPD  = 2'd2
  } state_e;

  typedef struct packed {
    logic [TICKET_BITS-1:0] ticket;
    logic [NAME_W-1:0]      name;
  } entry_t;

  // Controller to datapath strobes
  typedef struct packed {
    logic capture;
    logic compare;
    logic commit;
  } dtq_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;
  } dtq_stat_t;

endpackage

/* rtl/dtq_row.sv */
// One queue as a row of entry cells with parallel compare, shift and tail write.
module dtq_row (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            compare_i,
  input  dtq_pkg::row_op_e                op_i,
  input  dtq_pkg::entry_t                 entry_i,
  input  logic [dtq_pkg::TICKET_BITS-1:0] key_i,
  output dtq_pkg::entry_t                 head_o,
  output logic [dtq_pkg::FILL_W-1:0]      fill_o,
  output logic                            full_o,
  output logic                            empty_o
);

  localparam int D = dtq_pkg::DEPTH;
  localparam int FW = dtq_pkg::FILL_W;

  dtq_pkg::entry_t cell_q [D];
  dtq_pkg::entry_t cell_d [D];
  logic [D-1:0]    ge_q;
  logic            head_gt_q;
  logic [FW-1:0]   fill_q, fill_d;
  logic [D-1:0]    hit, after;
  logic            front;

  assign head_o  = cell_q[0];
  assign fill_o  = fill_q;
  assign full_o  = (fill_q == FW'(D));
  assign empty_o = (fill_q == '0);

  // Latch per-cell compares against the new ticket
  always_ff @(posedge clk_i) begin
    if (compare_i) begin
      for (int i = 0; i < D; i++) begin
        ge_q[i] <= (cell_q[i].ticket >= key_i);
      end
      head_gt_q <= (cell_q[0].ticket > key_i);
    end
  end

  // Locate the insert slot: first later cell not smaller, else the tail
  always_comb begin
    front = empty_o || head_gt_q;
    for (int i = 0; i < D; i++) begin
      hit[i] = ((i != 0) && (FW'(i) < fill_q) && ge_q[i]) || (FW'(i) == fill_q);
    end
    for (int i = 0; i < D; i++) begin
      after[i] = front || (|(hit & ((D'(1) << (i + 1)) - D'(1))));
    end
  end

  // Per-cell next value
  always_comb begin
    int prv;
    int nxt;
    for (int i = 0; i < D; i++) begin
      prv = (i == 0) ? 0 : i - 1;
      nxt = (i == D - 1) ? i : i + 1;
      cell_d[i] = cell_q[i];
      unique case (op_i)
        dtq_pkg::ROW_PUSH: begin
          if (FW'(i) == fill_q) cell_d[i] = entry_i;
        end
        dtq_pkg::ROW_INSERT: begin
          if (after[i]) begin
            if (i == 0 || !after[prv]) cell_d[i] = entry_i;
            else cell_d[i] = cell_q[prv];
          end
        end
        dtq_pkg::ROW_POP: begin
          cell_d[i] = cell_q[nxt];
        end
        default: begin
          cell_d[i] = cell_q[i];
        end
      endcase
    end
  end

  // Track the fill count
  always_comb begin
    case (op_i)
      dtq_pkg::ROW_PUSH, dtq_pkg::ROW_INSERT: fill_d = fill_q + FW'(1);
      dtq_pkg::ROW_POP:                       fill_d = fill_q - FW'(1);
      default:                                fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < D; i++) begin
      cell_q[i] <= cell_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

endmodule

/* rtl/dtq_ctrl.sv */
// Sequencer: capture a command, compare, then commit into the output register.
module dtq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dtq_pkg::dtq_stat_t stat_i,
  output dtq_pkg::dtq_cmd_t  cmd_o
);

  dtq_pkg::state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dtq_pkg::S_IDLE: if (in_valid_i) state_d = dtq_pkg::S_CMP;
      dtq_pkg::S_CMP:  state_d = dtq_pkg::S_UPD;
      dtq_pkg::S_UPD:  if (stat_i.out_free) state_d = dtq_pkg::S_IDLE;
      default:         state_d = dtq_pkg::S_IDLE;
    endcase
  end

  // Strobes
  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.compare = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      dtq_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      dtq_pkg::S_CMP: cmd_o.compare = 1'b1;
      dtq_pkg::S_UPD: cmd_o.commit  = stat_i.out_free;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dtq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/dtq_datapath.sv */
// Command register, the two queue rows and the result register.
module dtq_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dtq_pkg::dtq_cmd_t                cmd_i,
  output dtq_pkg::dtq_stat_t               stat_o,
  input  logic [dtq_pkg::CMD_W-1:0]        command_i,
  input  logic                             queue_select_i,
  input  logic [dtq_pkg::TKT_W-1:0]        entry_ticket_i,
  input  logic [dtq_pkg::NAME_W-1:0]       entry_name_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [dtq_pkg::STATUS_W-1:0]     status_o,
  output logic [dtq_pkg::TKT_W-1:0]        taken_ticket_o,
  output logic [dtq_pkg::NAME_W-1:0]       taken_name_o,
  output logic [dtq_pkg::COUNT_W-1:0]      first_count_o,
  output logic [dtq_pkg::COUNT_W-1:0]      second_count_o
);

  localparam int FW = dtq_pkg::FILL_W;

  dtq_pkg::cmd_e    cmd_q;
  logic             sel_q;
  dtq_pkg::entry_t  new_q;

  dtq_pkg::row_op_e op   [2];
  dtq_pkg::entry_t  ent  [2];
  dtq_pkg::entry_t  head [2];
  logic [FW-1:0]    fill [2];
  logic [FW-1:0]    cnt  [2];
  logic [1:0]       full, empty;

  dtq_pkg::status_e            st;
  logic [dtq_pkg::TKT_W-1:0]  tk;
  logic [dtq_pkg::NAME_W-1:0] nm;

  logic                             out_valid_q;
  dtq_pkg::status_e                 status_q;
  logic [dtq_pkg::TKT_W-1:0]        taken_ticket_q;
  logic [dtq_pkg::NAME_W-1:0]       taken_name_q;
  logic [dtq_pkg::COUNT_W-1:0]      first_count_q, second_count_q;

  // Capture the input beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q       <= dtq_pkg::cmd_e'(command_i);
      sel_q       <= queue_select_i;
      new_q.ticket <= dtq_pkg::TICKET_BITS'(entry_ticket_i);
      new_q.name   <= entry_name_i;
    end
  end

  for (genvar r = 0; r < 2; r++) begin : g_row
    dtq_row u_row (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .compare_i (cmd_i.compare),
      .op_i      (op[r]),
      .entry_i   (ent[r]),
      .key_i     (new_q.ticket),
      .head_o    (head[r]),
      .fill_o    (fill[r]),
      .full_o    (full[r]),
      .empty_o   (empty[r])
    );
  end

  // Decode the command into row operations and a result
  always_comb begin
    op[0]  = dtq_pkg::ROW_HOLD;
    op[1]  = dtq_pkg::ROW_HOLD;
    ent[0] = new_q;
    ent[1] = new_q;
    st     = dtq_pkg::ST_DONE;
    tk     = '0;
    nm     = '0;
    unique case (cmd_q)
      dtq_pkg::CMD_APPEND: begin
        if (full[sel_q]) st = dtq_pkg::ST_FULL;
        else op[sel_q] = dtq_pkg::ROW_PUSH;
      end
      dtq_pkg::CMD_INSERT: begin
        if (full[sel_q]) st = dtq_pkg::ST_FULL;
        else op[sel_q] = dtq_pkg::ROW_INSERT;
      end
      dtq_pkg::CMD_REMOVE: begin
        if (empty[sel_q]) begin
          st = dtq_pkg::ST_EMPTY;
        end else begin
          op[sel_q] = dtq_pkg::ROW_POP;
          tk = dtq_pkg::TKT_W'(head[sel_q].ticket);
          nm = head[sel_q].name;
        end
      end
      dtq_pkg::CMD_MOVE: begin
        if (empty[sel_q]) begin
          st = dtq_pkg::ST_EMPTY;
        end else if (full[!sel_q]) begin
          st = dtq_pkg::ST_FULL;
        end else begin
          op[sel_q]  = dtq_pkg::ROW_POP;
          op[!sel_q] = dtq_pkg::ROW_PUSH;
          ent[!sel_q] = head[sel_q];
          tk = dtq_pkg::TKT_W'(head[sel_q].ticket);
          nm = head[sel_q].name;
        end
      end
      default: begin
        st = dtq_pkg::ST_DONE;
      end
    endcase
    // Hold both rows outside the commit cycle
    if (!cmd_i.commit) begin
      op[0] = dtq_pkg::ROW_HOLD;
      op[1] = dtq_pkg::ROW_HOLD;
    end
  end

  // Counts after this command
  always_comb begin
    for (int r = 0; r < 2; r++) begin
      case (op[r])
        dtq_pkg::ROW_PUSH, dtq_pkg::ROW_INSERT: cnt[r] = fill[r] + FW'(1);
        dtq_pkg::ROW_POP:                       cnt[r] = fill[r] - FW'(1);
        default:                                cnt[r] = fill[r];
      endcase
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q       <= st;
      taken_ticket_q <= tk;
      taken_name_q   <= nm;
      first_count_q  <= dtq_pkg::COUNT_W'(cnt[0]);
      second_count_q <= dtq_pkg::COUNT_W'(cnt[1]);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign taken_ticket_o = taken_ticket_q;
  assign taken_name_o   = taken_name_q;
  assign first_count_o  = first_count_q;
  assign second_count_o = second_count_q;

endmodule

/* rtl/dual_ticket_queue.sv */
// Top level of the dual ticket queue: sequencer plus datapath.
//
// Two bounded queues of (ticket, name) entries. Each input beat carries one
// command (append, priority insert, remove head, move head to the other
// queue) for the queue picked by queue_select_i; each command yields exactly
// one output beat with status, the entry taken out (zero if none) and both
// queue counts after the command.
// Both channels are valid/ready. An input beat is taken when the sequencer is
// idle; the command then passes a compare step, latching the parallel ticket
// compares of the queue cell row, and an update step, shifting the row and
// loading the result register. A new input beat is accepted only once the
// previous command has committed.
// The result register lets the next command be accepted while a result
// still waits. If the receiver stalls, the following command waits in its
// update step until the result register frees up, then commits.
// Reset empties both queues (counts go to zero) and clears the output valid;
// entry storage is not cleared, only filled cells are ever read.
module dual_ticket_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [dtq_pkg::CMD_W-1:0]    command_i,
  input  logic                         queue_select_i,
  input  logic [dtq_pkg::TKT_W-1:0]    entry_ticket_i,
  input  logic [dtq_pkg::NAME_W-1:0]   entry_name_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [dtq_pkg::STATUS_W-1:0] status_o,
  output logic [dtq_pkg::TKT_W-1:0]    taken_ticket_o,
  output logic [dtq_pkg::NAME_W-1:0]   taken_name_o,
  output logic [dtq_pkg::COUNT_W-1:0]  first_count_o,
  output logic [dtq_pkg::COUNT_W-1:0]  second_count_o
);

  dtq_pkg::dtq_cmd_t  cmd;
  dtq_pkg::dtq_stat_t stat;

  dtq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dtq_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .command_i      (command_i),
    .queue_select_i (queue_select_i),
    .entry_ticket_i (entry_ticket_i),
    .entry_name_i   (entry_name_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .taken_ticket_o (taken_ticket_o),
    .taken_name_o   (taken_name_o),
    .first_count_o  (first_count_o),
    .second_count_o (second_count_o)
  );

  // Only one sequencer strobe at a time
  a_one_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.capture, cmd.compare, cmd.commit}))
    else $error("more than one sequencer strobe active");

  // A commit always presents a result next cycle
  a_commit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_o)
    else $error("commit without output beat");

  // An accepted beat keeps the input closed while it is worked on
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (!in_ready_o && cmd.compare))
    else $error("input reopened before compare step");

  // Commit only happens when the result register can take it
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten while stalled");

endmodule
